// ===== design/dda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  localparam int unsigned GYRO_W     = 16;
  localparam int unsigned TILT_W     = 15;
  localparam int unsigned MIN_SPD_W  = 7;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned SERVO_W    = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // register reset values, truncated to the converter width where it applies
  localparam int unsigned WHEEL_REST_RESET  = 512;
  localparam int unsigned WHEEL_THRSH_RESET = 20;
  localparam logic [TILT_W-1:0]    TILT_THRSH_RESET = TILT_W'(30);
  localparam logic [MIN_SPD_W-1:0] MIN_SPEED_RESET  = MIN_SPD_W'(40);

  localparam logic [SERVO_W-1:0] SERVO_0   = SERVO_W'(0);
  localparam logic [SERVO_W-1:0] SERVO_60  = SERVO_W'(60);
  localparam logic [SERVO_W-1:0] SERVO_120 = SERVO_W'(120);
  localparam logic [SERVO_W-1:0] SERVO_180 = SERVO_W'(180);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GYRO_X_REST  = 3'd0,
    REG_GYRO_Y_REST  = 3'd1,
    REG_WHEEL_REST   = 3'd2,
    REG_TILT_THRSH   = 3'd3,
    REG_WHEEL_THRSH  = 3'd4,
    REG_MIN_SPEED    = 3'd5
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE      = 3'd0,
    STATUS_ONE       = 3'd1,
    STATUS_BOTH      = 3'd2,
    STATUS_INSECURE  = 3'd3,
    STATUS_IMPRUDENT = 3'd4,
    STATUS_COLLISION = 3'd5
  } status_e;

  // driver symptoms of one sample set
  typedef struct packed {
    logic head;   // tilt or unmatched head turning
    logic steer;  // sharp steering at speed
  } sym_t;

endpackage

`default_nettype wire

// ===== design/dda_head.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dda_head #(
  parameter int unsigned ADC_BITS = 10,
  parameter int unsigned SPEED_W  = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dda_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  wire logic [dda_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                 fire_i,
  input  wire logic [dda_pkg::GYRO_W-1:0]           gyro_x_i,
  input  wire logic [dda_pkg::GYRO_W-1:0]           gyro_y_i,
  input  wire logic [ADC_BITS-1:0]                  wheel_angle_i,
  input  wire logic [ADC_BITS-1:0]                  speed_raw_i,
  output dda_pkg::sym_t                             sym_o,
  output logic [SPEED_W-1:0]                        speed_hi_o
);

  // floor(speed_raw / 100) by reciprocal multiplication, exact over the input range
  localparam int unsigned RECIP_SH = ADC_BITS + 7;
  localparam int unsigned RECIP_W  = ADC_BITS + 1;
  localparam int unsigned PROD_W   = 2 * ADC_BITS + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** RECIP_SH) + 99) / 100);
  localparam int unsigned DEV_W = dda_pkg::GYRO_W + 1;
  localparam int unsigned WHL_W = ADC_BITS + 2;
  localparam int unsigned SPD_CMP_W = 17;

  logic [dda_pkg::GYRO_W-1:0]    gx_rest_q, gy_rest_q;
  logic [ADC_BITS-1:0]           wheel_rest_q, wheel_thr_q;
  logic [dda_pkg::TILT_W-1:0]    tilt_thr_q;
  logic [dda_pkg::MIN_SPD_W-1:0] min_speed_q;

  logic signed [DEV_W-1:0] prev_x_q, prev_y_q;
  logic [ADC_BITS-1:0]     steer_ref_q, steer_ref_d;
  logic                    ref_valid_q;

  logic signed [DEV_W-1:0] dx, dy, thr_pos, thr_neg;
  logic                    tilt, y_pos, y_neg, right_turn, left_turn, head_sym;
  logic signed [WHL_W-1:0] wheel_s, wt_s, win_hi, win_lo, ref_s, diff;
  logic [ADC_BITS-1:0]     ref_cur;
  logic [SPD_CMP_W-1:0]    speed_lim;
  logic                    fast, sharp;
  logic [PROD_W-1:0]       prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_rest_q    <= '0;
      gy_rest_q    <= '0;
      wheel_rest_q <= ADC_BITS'(dda_pkg::WHEEL_REST_RESET);
      wheel_thr_q  <= ADC_BITS'(dda_pkg::WHEEL_THRSH_RESET);
      tilt_thr_q   <= dda_pkg::TILT_THRSH_RESET;
      min_speed_q  <= dda_pkg::MIN_SPEED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dda_pkg::REG_GYRO_X_REST: gx_rest_q    <= cfg_data_i;
        dda_pkg::REG_GYRO_Y_REST: gy_rest_q    <= cfg_data_i;
        dda_pkg::REG_WHEEL_REST:  wheel_rest_q <= cfg_data_i[ADC_BITS-1:0];
        dda_pkg::REG_TILT_THRSH:  tilt_thr_q   <= cfg_data_i[dda_pkg::TILT_W-1:0];
        dda_pkg::REG_WHEEL_THRSH: wheel_thr_q  <= cfg_data_i[ADC_BITS-1:0];
        dda_pkg::REG_MIN_SPEED:   min_speed_q  <= cfg_data_i[dda_pkg::MIN_SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // head symptom: deviation from rest beyond threshold on this and the previous sample
  always_comb begin
    dx      = $signed({gyro_x_i[dda_pkg::GYRO_W-1], gyro_x_i})
            - $signed({gx_rest_q[dda_pkg::GYRO_W-1], gx_rest_q});
    dy      = $signed({gyro_y_i[dda_pkg::GYRO_W-1], gyro_y_i})
            - $signed({gy_rest_q[dda_pkg::GYRO_W-1], gy_rest_q});
    thr_pos = $signed({2'b00, tilt_thr_q});
    thr_neg = -thr_pos;
    tilt    = (dx >= thr_pos && prev_x_q >= thr_pos) ||
              (dx <= thr_neg && prev_x_q <= thr_neg);
    y_pos   = dy >= thr_pos && prev_y_q >= thr_pos;
    y_neg   = dy <= thr_neg && prev_y_q <= thr_neg;

    wheel_s    = $signed({2'b00, wheel_angle_i});
    wt_s       = $signed({2'b00, wheel_thr_q});
    win_hi     = $signed({2'b00, wheel_rest_q}) + wt_s;
    win_lo     = $signed({2'b00, wheel_rest_q}) - wt_s;
    right_turn = wheel_s > win_hi && y_pos;
    left_turn  = wheel_s < win_lo && y_neg;
    head_sym   = tilt || ((y_pos || y_neg) && !(right_turn || left_turn));
  end

  // steering symptom against the latched reference; first sample loads it
  always_comb begin
    ref_cur   = ref_valid_q ? steer_ref_q : wheel_angle_i;
    ref_s     = $signed({2'b00, ref_cur});
    diff      = ref_s - wheel_s;
    // speed_raw / 10 >= min_speed  <=>  speed_raw >= 10 * min_speed
    speed_lim = SPD_CMP_W'({min_speed_q, 3'b000}) + SPD_CMP_W'({min_speed_q, 1'b0});
    fast      = SPD_CMP_W'(speed_raw_i) >= speed_lim;
    sharp     = (diff >= wt_s || diff <= -wt_s) && fast;
    steer_ref_d = sharp ? ref_cur : wheel_angle_i;
  end

  assign sym_o = '{head: head_sym, steer: sharp};

  assign prod       = PROD_W'(speed_raw_i) * PROD_W'(RECIP);
  assign speed_hi_o = prod[RECIP_SH +: SPEED_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      steer_ref_q <= '0;
      ref_valid_q <= 1'b0;
    end else if (fire_i) begin
      prev_x_q    <= dx;
      prev_y_q    <= dy;
      steer_ref_q <= steer_ref_d;
      ref_valid_q <= 1'b1;
    end
  end

  a_ref_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> ref_valid_q)
    else $error("steering reference not loaded after a sample");

  a_ref_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ref_valid_q && sym_o.steer |=> $stable(steer_ref_q))
    else $error("steering reference moved during sharp steering");

endmodule

`default_nettype wire

// ===== design/dda_grade.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dda_grade #(
  parameter int unsigned SPEED_W = 4
) (
  input  wire logic [SPEED_W-1:0]             speed_hi_i,
  input  wire logic [dda_pkg::DIST_W-1:0]     distance_i,
  input  wire dda_pkg::sym_t                  sym_i,
  output logic                                led_one_o,
  output logic                                led_two_o,
  output logic [dda_pkg::SERVO_W-1:0]         servo_angle_o,
  output dda_pkg::status_e                    status_o
);

  localparam int unsigned SAFE_W = 2 * SPEED_W;
  localparam int unsigned CMP_W  = (SAFE_W > 15) ? SAFE_W : 15;

  logic [SAFE_W-1:0] safe;
  logic [CMP_W-1:0]  safe_x, dist_x, dist_p1, dist_x2, dist_x3;
  logic              collision, imprudent, insecure, any_sym;

  assign safe = SAFE_W'(speed_hi_i) * SAFE_W'(speed_hi_i);

  // dist < floor(safe / k)  <=>  k * (dist + 1) <= safe
  always_comb begin
    safe_x    = CMP_W'(safe);
    dist_x    = CMP_W'(distance_i);
    dist_p1   = dist_x + CMP_W'(1);
    dist_x2   = {dist_p1[CMP_W-2:0], 1'b0};
    dist_x3   = dist_x2 + dist_p1;
    collision = dist_x3 <= safe_x;
    imprudent = dist_x2 <= safe_x;
    insecure  = dist_x < safe_x;
  end

  always_comb begin
    any_sym = sym_i.head || sym_i.steer;
    led_one_o     = 1'b1;
    led_two_o     = 1'b1;
    servo_angle_o = dda_pkg::SERVO_0;
    status_o      = dda_pkg::STATUS_NONE;
    priority if (collision) begin
      servo_angle_o = dda_pkg::SERVO_180;
      status_o      = dda_pkg::STATUS_COLLISION;
    end else if (any_sym && imprudent) begin
      servo_angle_o = dda_pkg::SERVO_120;
      status_o      = dda_pkg::STATUS_IMPRUDENT;
    end else if (any_sym && insecure) begin
      servo_angle_o = dda_pkg::SERVO_60;
      status_o      = dda_pkg::STATUS_INSECURE;
    end else begin
      // near distance without a symptom leaves everything off
      led_two_o = sym_i.head && sym_i.steer && !insecure;
      led_one_o = any_sym && !insecure;
      if (led_two_o) begin
        status_o = dda_pkg::STATUS_BOTH;
      end else if (led_one_o) begin
        status_o = dda_pkg::STATUS_ONE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/driver_distraction_alarm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted sample set is registered in stage one, then in the result register
// throughput: one set per cycle unless stalled; the symptom history updates on accept
// a stalled output holds its result while one more sample set waits in stage one
// reset (async, active low) sets registers to defaults and clears gyro history
// and the steering reference; no memory, so no clearing pass

module driver_distraction_alarm #(
  parameter int unsigned ADC_BITS = 10
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [dda_pkg::CFG_ADDR_W-1:0]          cfg_addr_i,
  input  wire logic [dda_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // gyro_x[15:0], gyro_y[31:16], wheel_angle, speed_raw, distance, zero pad
  input  wire logic [((2*ADC_BITS+44+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // led_one[0], led_two[1], servo_angle[9:2], status[12:10], zero pad
  output logic [dda_pkg::OUT_DATA_W-1:0]               m_axis_tdata
);

  localparam int unsigned SPEED_W = $clog2(((2 ** ADC_BITS) - 1) / 100 + 1);
  localparam int unsigned WHL_LSB = 2 * dda_pkg::GYRO_W;
  localparam int unsigned SPD_LSB = WHL_LSB + ADC_BITS;
  localparam int unsigned DST_LSB = SPD_LSB + ADC_BITS;
  localparam int unsigned OUT_USED = 2 + dda_pkg::SERVO_W + dda_pkg::STATUS_W;

  logic                         s_fire, mid_adv, out_adv;
  dda_pkg::sym_t                sym, sym_q;
  logic [SPEED_W-1:0]           speed_hi, speed_hi_q;
  logic [dda_pkg::DIST_W-1:0]   dist_q;
  logic                         mid_valid_q, out_valid_q;
  logic                         led_one, led_two;
  logic [dda_pkg::SERVO_W-1:0]  servo;
  dda_pkg::status_e             status;
  logic [OUT_USED-1:0]          out_q;

  assign cfg_ready_o = 1'b1;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign mid_adv       = !mid_valid_q || out_adv;
  assign s_axis_tready = mid_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  dda_head #(
    .ADC_BITS (ADC_BITS),
    .SPEED_W  (SPEED_W)
  ) u_head (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .fire_i        (s_fire),
    .gyro_x_i      (s_axis_tdata[dda_pkg::GYRO_W-1:0]),
    .gyro_y_i      (s_axis_tdata[dda_pkg::GYRO_W +: dda_pkg::GYRO_W]),
    .wheel_angle_i (s_axis_tdata[WHL_LSB +: ADC_BITS]),
    .speed_raw_i   (s_axis_tdata[SPD_LSB +: ADC_BITS]),
    .sym_o         (sym),
    .speed_hi_o    (speed_hi)
  );

  // stage one: symptoms, scaled speed and distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (mid_adv) begin
      mid_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      sym_q      <= sym;
      speed_hi_q <= speed_hi;
      dist_q     <= s_axis_tdata[DST_LSB +: dda_pkg::DIST_W];
    end
  end

  dda_grade #(
    .SPEED_W (SPEED_W)
  ) u_grade (
    .speed_hi_i    (speed_hi_q),
    .distance_i    (dist_q),
    .sym_i         (sym_q),
    .led_one_o     (led_one),
    .led_two_o     (led_two),
    .servo_angle_o (servo),
    .status_o      (status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && mid_valid_q) begin
      out_q <= {status, servo, led_two, led_one};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dda_pkg::OUT_DATA_W'(out_q);

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> mid_valid_q)
    else $error("accepted sample set missing from stage one");

  a_mid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid_q && !out_adv |=> mid_valid_q && $stable(dist_q))
    else $error("stage one dropped a transaction under stall");

  a_none_servo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12:10] == dda_pkg::STATUS_NONE |->
      m_axis_tdata[9:2] == dda_pkg::SERVO_0 && m_axis_tdata[1:0] == 2'b00)
    else $error("idle status with lamps or servo active");

endmodule

`default_nettype wire
